>>> rtl/core/prq_pkg.sv
// Package: shared types and constants of the priority ready queue.
`default_nettype none
package prq_pkg;

  localparam int unsigned LEVELS_DEF    = 32;
  localparam int unsigned MAX_TASKS_DEF = 64;

  typedef enum logic [1:0] {
    OP_ENQ = 2'd0,
    OP_REM = 2'd1,
    OP_SEL = 2'd2,
    OP_POP = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LV_WAIT,
    ST_TK_WAIT,
    ST_UNLINK,
    ST_ENQ_B,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [5:0] task_req;
    logic [4:0] level;
    logic       activation;
  } req_t;

  typedef struct packed {
    logic       status;
    logic       found;
    logic [5:0] chosen_task;
    logic       chosen_activation;
    logic [6:0] queued_total;
  } res_t;

endpackage
`default_nettype wire

>>> rtl/core/prq_core.sv
// Sequencer, link memories and bitmap of the priority ready queue.
`default_nettype none
module prq_core #(
  parameter int unsigned LEVELS    = prq_pkg::LEVELS_DEF,
  parameter int unsigned MAX_TASKS = prq_pkg::MAX_TASKS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire prq_pkg::req_t req,
  input  wire logic        room,
  output logic             busy,
  output logic             done,
  output prq_pkg::res_t    res
);
  import prq_pkg::*;

  localparam int unsigned TW   = $clog2(MAX_TASKS);
  localparam int unsigned LW   = $clog2(LEVELS);
  localparam int unsigned CNTW = $clog2(MAX_TASKS + 1);

  state_t state_r, state_nxt;
  logic [1:0]      op_r, op_nxt;
  logic [5:0]      t_r, t_nxt;
  logic [4:0]      lv_r, lv_nxt;
  logic            act_r, act_nxt;
  logic [LW-1:0]   la_r, la_nxt;
  logic [TW-1:0]   cur_r, cur_nxt;
  logic            hc_r, hc_nxt;
  logic [LEVELS-1:0]    map_r, map_nxt;
  logic [MAX_TASKS-1:0] queued_r, queued_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic            turn_r, turn_nxt;
  logic            stat_r, stat_nxt, found_r, found_nxt, pact_r, pact_nxt;
  logic [TW-1:0]   pick_r, pick_nxt;

  logic [TW-1:0] next_mem [MAX_TASKS];
  logic [TW-1:0] prev_mem [MAX_TASKS];
  logic [4:0]    tlvl_mem [MAX_TASKS];
  logic          cred_mem [MAX_TASKS];
  logic [TW-1:0] head_mem [LEVELS];
  logic [TW-1:0] tail_mem [LEVELS];

  logic [TW-1:0] nx_q, pv_q, head_q, tail_q;
  logic [4:0]    tlvl_q;
  logic          cred_q;

  logic          nx_we, pv_we, tk_we, hd_we, tl_we, lvl_re;
  logic [TW-1:0] nx_wa, nx_wd, pv_wa, pv_wd, hd_wd, tl_wd;

  logic [TW-1:0] ti;
  logic          t_ok, lv_ok;
  logic [LW-1:0] top;

  assign ti    = TW'(t_r);
  assign t_ok  = (9'(t_r) < 9'(MAX_TASKS));
  assign lv_ok = (6'(lv_r) < 6'(LEVELS));

  always_comb begin
    top = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (map_r[i]) top = LW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    if (pv_we) prev_mem[pv_wa] <= pv_wd;
    if (tk_we) begin
      tlvl_mem[ti] <= lv_r;
      cred_mem[ti] <= act_r;
    end
    nx_q   <= next_mem[cur_nxt];
    pv_q   <= prev_mem[cur_nxt];
    tlvl_q <= tlvl_mem[cur_nxt];
    cred_q <= cred_mem[cur_nxt];
  end

  always_ff @(posedge clk) begin
    if (hd_we) head_mem[la_r] <= hd_wd;
    if (tl_we) tail_mem[la_r] <= tl_wd;
    if (lvl_re) begin
      head_q <= head_mem[la_nxt];
      tail_q <= tail_mem[la_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      map_r    <= '0;
      queued_r <= '0;
      count_r  <= '0;
      turn_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      map_r    <= map_nxt;
      queued_r <= queued_nxt;
      count_r  <= count_nxt;
      turn_r   <= turn_nxt;
    end
    op_r    <= op_nxt;
    t_r     <= t_nxt;
    lv_r    <= lv_nxt;
    act_r   <= act_nxt;
    la_r    <= la_nxt;
    cur_r   <= cur_nxt;
    hc_r    <= hc_nxt;
    stat_r  <= stat_nxt;
    found_r <= found_nxt;
    pact_r  <= pact_nxt;
    pick_r  <= pick_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    t_nxt      = t_r;
    lv_nxt     = lv_r;
    act_nxt    = act_r;
    la_nxt     = la_r;
    cur_nxt    = cur_r;
    hc_nxt     = hc_r;
    map_nxt    = map_r;
    queued_nxt = queued_r;
    count_nxt  = count_r;
    turn_nxt   = turn_r;
    stat_nxt   = stat_r;
    found_nxt  = found_r;
    pact_nxt   = pact_r;
    pick_nxt   = pick_r;
    nx_we = 1'b0; nx_wa = cur_r; nx_wd = cur_r;
    pv_we = 1'b0; pv_wa = cur_r; pv_wd = cur_r;
    tk_we = 1'b0;
    hd_we = 1'b0; hd_wd = cur_r;
    tl_we = 1'b0; tl_wd = cur_r;
    lvl_re = 1'b0;
    done   = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt    = req.operation;
          t_nxt     = req.task_req;
          lv_nxt    = req.level;
          act_nxt   = req.activation;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        stat_nxt  = 1'b0;
        found_nxt = 1'b0;
        pact_nxt  = 1'b0;
        pick_nxt  = '0;
        lvl_re    = 1'b1;
        la_nxt    = LW'(lv_r);
        state_nxt = ST_LV_WAIT;
        case (op_t'(op_r))
          OP_ENQ: begin
            if (!t_ok || !lv_ok || queued_r[ti]) begin
              stat_nxt  = 1'b1;
              state_nxt = ST_RESP;
            end
          end
          OP_REM: begin
            if (!t_ok || !lv_ok || !queued_r[ti]) begin
              stat_nxt  = 1'b1;
              state_nxt = ST_RESP;
            end
          end
          OP_SEL: begin
            la_nxt = top;
            if (map_r == '0) begin
              turn_nxt  = 1'b0;
              state_nxt = ST_RESP;
            end
          end
          OP_POP: begin
            if (!lv_ok) begin
              stat_nxt  = 1'b1;
              state_nxt = ST_RESP;
            end else if (!map_r[LW'(lv_r)]) begin
              state_nxt = ST_RESP;
            end
          end
          default: state_nxt = ST_RESP;
        endcase
      end
      ST_LV_WAIT: begin
        if (op_t'(op_r) == OP_ENQ) begin
          tk_we = 1'b1;
          nx_we = 1'b1; nx_wa = ti; nx_wd = ti;
          pv_we = 1'b1; pv_wa = ti; pv_wd = map_r[la_r] ? tail_q : ti;
          tl_we = 1'b1; tl_wd = ti;
          hd_we = !map_r[la_r]; hd_wd = ti;
          map_nxt[la_r]  = 1'b1;
          queued_nxt[ti] = 1'b1;
          count_nxt      = count_r + CNTW'(1);
          state_nxt      = map_r[la_r] ? ST_ENQ_B : ST_RESP;
        end else begin
          cur_nxt   = (op_t'(op_r) == OP_REM) ? ti : head_q;
          state_nxt = ST_TK_WAIT;
        end
      end
      ST_TK_WAIT: begin
        case (op_t'(op_r))
          OP_REM: begin
            if (tlvl_q != lv_r) begin
              stat_nxt  = 1'b1;
              state_nxt = ST_RESP;
            end else begin
              state_nxt = ST_UNLINK;
            end
          end
          OP_POP: begin
            found_nxt = 1'b1;
            pick_nxt  = cur_r;
            pact_nxt  = cred_q;
            state_nxt = ST_UNLINK;
          end
          OP_SEL: begin
            if (cur_r == head_q) hc_nxt = cred_q;
            if (cred_q == !turn_r) begin
              found_nxt = 1'b1;
              pick_nxt  = cur_r;
              pact_nxt  = cred_q;
              turn_nxt  = cred_q;
              state_nxt = ST_RESP;
            end else if (cur_r == tail_q) begin
              found_nxt = 1'b1;
              pick_nxt  = head_q;
              pact_nxt  = (cur_r == head_q) ? cred_q : hc_r;
              turn_nxt  = (cur_r == head_q) ? cred_q : hc_r;
              state_nxt = ST_RESP;
            end else begin
              cur_nxt = nx_q;
            end
          end
          default: state_nxt = ST_RESP;
        endcase
      end
      ST_UNLINK: begin
        if (head_q == cur_r && tail_q == cur_r) begin
          map_nxt[la_r] = 1'b0;
        end else if (head_q == cur_r) begin
          hd_we = 1'b1; hd_wd = nx_q;
          pv_we = 1'b1; pv_wa = nx_q; pv_wd = nx_q;
        end else if (tail_q == cur_r) begin
          tl_we = 1'b1; tl_wd = pv_q;
          nx_we = 1'b1; nx_wa = pv_q; nx_wd = pv_q;
        end else begin
          nx_we = 1'b1; nx_wa = pv_q; nx_wd = nx_q;
          pv_we = 1'b1; pv_wa = nx_q; pv_wd = pv_q;
        end
        queued_nxt[cur_r] = 1'b0;
        if (count_r != '0) count_nxt = count_r - CNTW'(1);
        state_nxt = ST_RESP;
      end
      ST_ENQ_B: begin
        nx_we = 1'b1; nx_wa = tail_q; nx_wd = ti;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (room) begin
          done      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    res.status            = stat_r;
    res.found             = found_r;
    res.chosen_task       = 6'(pick_r);
    res.chosen_activation = pact_r;
    res.queued_total      = 7'(count_r);
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(MAX_TASKS))
    else $error("queued count out of range");

  a_count_bits: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(queued_r) == 32'(count_r))
    else $error("queued count disagrees with queued flags");

  a_map_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) == (map_r == '0))
    else $error("level bitmap disagrees with queued count");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> state_r == ST_IDLE)
    else $error("sequencer not idle after request");

endmodule
`default_nettype wire

>>> rtl/core/priority_ready_queue_unit.sv
// Top level of the priority ready queue: handshakes and result register.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_valid / in_ready  | in_data  (prq_pkg::req_t)
//  out_    | out | out_valid / out_ready| out_data (prq_pkg::res_t)
//
// Enqueue on a non-empty level adds state ST_ENQ_B to link the old tail;
// remove and pop read the level and the task, then unlink it. A request
// rejected at decode, or a pop of an empty level, skips to ST_RESP. Select
// walks the top level (at most MAX_TASKS tasks), one link memory read per step.
// rst_n is synchronous; it clears the bitmap, queued flags, count and turn flag.
// A held result does not stop the next request being taken; the sequencer
// waits only if the result register is still full when it finishes.
`default_nettype none
module priority_ready_queue_unit #(
  parameter int unsigned LEVELS    = prq_pkg::LEVELS_DEF,
  parameter int unsigned MAX_TASKS = prq_pkg::MAX_TASKS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire prq_pkg::req_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output prq_pkg::res_t out_data
);
  import prq_pkg::*;

  logic busy, done, room;
  res_t res;
  logic out_valid_r;
  res_t out_data_r;

  assign in_ready = !busy;
  assign room     = !out_valid_r || out_ready;

  prq_core #(
    .LEVELS    (LEVELS),
    .MAX_TASKS (MAX_TASKS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_valid && in_ready),
    .req   (in_data),
    .room  (room),
    .busy  (busy),
    .done  (done),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (done) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
